@@ rtl/sha256_pkg.sv @@
`default_nettype none
package sha256_pkg;

	localparam logic [31:0] K_TABLE [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PAD_BYTE  = 8'h80;
	localparam logic [5:0] PAD_LIMIT = 6'd56;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic        digest_last;
	} out_item_t;

	function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
		rotr = (v >> n) | (v << (32 - n));
	endfunction

endpackage
`default_nettype wire

@@ rtl/sha256_if.sv @@
`default_nettype none
interface sha256_in_if;
	logic                  valid;
	logic                  ready;
	sha256_pkg::in_item_t  payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface sha256_out_if;
	logic                  valid;
	logic                  ready;
	sha256_pkg::out_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ rtl/sha256_message_hasher.sv @@
// SHA-256 over a byte stream, at most one byte per input transfer. Every 64th byte
// starts the compression: 64 rounds of the single round unit, then a fold of the
// result into the chaining value. The end of a message pads the block (one or two
// extra compressions, the fold being followed by the ST_PAD2 state that loads the
// next pad block or starts the digest) and then offers the eight digest words as
// eight output transfers, the last one flagged. The block takes no input while it
// compresses or while the digest is being delivered.
`default_nettype none
module sha256_message_hasher (
	input  wire logic clk,
	input  wire logic arst_n,
	sha256_in_if.sink   in_ch,
	sha256_out_if.source out_ch
);
	import sha256_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_ROUND = 5'b00010,
		ST_FOLD  = 5'b00100,
		ST_PAD2  = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t      state_q;
	logic [31:0] w_q [16];
	logic [31:0] h_q [8];
	logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, hh_q;
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic [5:0]  round_q;
	logic [2:0]  emit_q;
	logic        final_q;
	logic        second_q;
	logic        pad_pending_q;

	logic [31:0] wt, s0w, s1w, wnext, t1, t2;
	logic [7:0]  dbyte;
	logic        acc;
	logic [5:0]  pos;
	logic [3:0]  widx;
	logic [4:0]  sh;

	assign in_ch.ready  = (state_q == ST_IDLE);
	assign out_ch.valid = (state_q == ST_EMIT);
	assign out_ch.payload.digest_word = h_q[emit_q];
	assign out_ch.payload.digest_last = (emit_q == 3'd7);
	assign acc   = in_ch.valid & in_ch.ready;
	assign dbyte = in_ch.payload.data_byte;
	assign pos   = fill_q;
	assign widx  = pos[5:2];
	assign sh    = {~pos[1:0], 3'b000};

	// Message schedule runs as a sliding window of sixteen words.
	assign wt    = w_q[0];
	assign s0w   = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
	assign s1w   = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
	assign wnext = w_q[0] + s0w + w_q[9] + s1w;
	assign t1 = hh_q + (rotr(e_q, 6) ^ rotr(e_q, 11) ^ rotr(e_q, 25))
		+ ((e_q & f_q) ^ (~e_q & g_q)) + K_TABLE[round_q] + wt;
	assign t2 = (rotr(a_q, 2) ^ rotr(a_q, 13) ^ rotr(a_q, 22))
		+ ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			bits_q   <= '0;
			round_q  <= '0;
			emit_q   <= '0;
			final_q  <= 1'b0;
			second_q <= 1'b0;
			for (int i = 0; i < 8; i++) h_q[i] <= H_INIT[i];
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						logic [31:0] nxt_blk [16];
						logic [5:0]  p;
						logic [63:0] nb;
						logic [3:0]  wi;
						logic [4:0]  s;
						logic        full;
						logic        pad_now;
						for (int i = 0; i < 16; i++) nxt_blk[i] = w_q[i];
						p    = fill_q;
						nb   = bits_q;
						full = 1'b0;
						if (in_ch.payload.has_byte) begin
							if (pos[1:0] == 2'd0) nxt_blk[widx] = {dbyte, 24'd0};
							else nxt_blk[widx] = nxt_blk[widx] | (32'(dbyte) << sh);
							nb   = bits_q + 64'd8;
							p    = fill_q + 6'd1;
							full = (fill_q == 6'd63);
						end
						wi = p[5:2];
						s  = {~p[1:0], 3'b000};
						pad_now = in_ch.payload.end_of_message && !full;
						if (pad_now) begin
							if (p[1:0] == 2'd0) nxt_blk[wi] = {PAD_BYTE, 24'd0};
							else nxt_blk[wi] = nxt_blk[wi] | (32'(PAD_BYTE) << s);
							for (int i = 0; i < 16; i++) begin
								if (i > int'(wi)) nxt_blk[i] = '0;
							end
							if (p < PAD_LIMIT) begin
								nxt_blk[14] = nb[63:32];
								nxt_blk[15] = nb[31:0];
							end
						end
						for (int i = 0; i < 16; i++) w_q[i] <= nxt_blk[i];
						bits_q   <= nb;
						fill_q   <= p;
						final_q  <= in_ch.payload.end_of_message;
						second_q <= pad_now && (p >= PAD_LIMIT);
						if (full || in_ch.payload.end_of_message) begin
							state_q <= ST_ROUND;
							round_q <= '0;
							a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
							e_q <= h_q[4]; f_q <= h_q[5]; g_q <= h_q[6]; hh_q <= h_q[7];
						end
					end
				end
				ST_ROUND: begin
					for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
					w_q[15] <= wnext;
					hh_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
					d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63) state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q; h_q[5] <= h_q[5] + f_q;
					h_q[6] <= h_q[6] + g_q; h_q[7] <= h_q[7] + hh_q;
					if (!final_q) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_PAD2;
					end
				end
				ST_PAD2: begin
					a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
					e_q <= h_q[4]; f_q <= h_q[5]; g_q <= h_q[6]; hh_q <= h_q[7];
					round_q <= '0;
					if (second_q) begin
						for (int i = 0; i < 14; i++) w_q[i] <= '0;
						w_q[14] <= bits_q[63:32];
						w_q[15] <= bits_q[31:0];
						second_q <= 1'b0;
						state_q <= ST_ROUND;
					end else if (pad_pending_q) begin
						w_q[0] <= {PAD_BYTE, 24'd0};
						for (int i = 1; i < 14; i++) w_q[i] <= '0;
						w_q[14] <= bits_q[63:32];
						w_q[15] <= bits_q[31:0];
						state_q <= ST_ROUND;
					end else begin
						emit_q  <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_ch.ready) begin
						emit_q <= emit_q + 3'd1;
						if (emit_q == 3'd7) begin
							state_q <= ST_IDLE;
							fill_q  <= '0;
							bits_q  <= '0;
							final_q <= 1'b0;
							for (int i = 0; i < 8; i++) h_q[i] <= H_INIT[i];
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// A full block that also ends the message needs a separate pad block
	// holding only the pad byte and the length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_pending_q <= 1'b0;
		end else if (acc) begin
			pad_pending_q <= in_ch.payload.has_byte && (fill_q == 6'd63)
				&& in_ch.payload.end_of_message;
		end else if (state_q == ST_PAD2) begin
			pad_pending_q <= 1'b0;
		end
	end

`ifndef SYNTH
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !out_ch.valid) else $error("ready while emitting");
	a_round_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && round_q != 6'd63) |=> state_q == ST_ROUND)
		else $error("round sequence broken");
	a_fold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && round_q == 6'd63) |=> state_q == ST_FOLD)
		else $error("missing fold");
	a_emit_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.ready && emit_q == 3'd7) |=> in_ch.ready)
		else $error("digest end not followed by idle");
`endif
endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import sha256_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	bit failed;

	sha256_in_if  in_ch ();
	sha256_out_if out_ch ();

	sha256_message_hasher uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	in_item_t   pending_bytes [$];
	out_item_t  digest_queue [$];
	logic [31:0] chain [8];
	logic [31:0] blk [16];
	logic [5:0]  fill;
	logic [63:0] bit_count;
	int  send_gap;
	int  recv_gap;
	int  hold_off;
	bit  stim_done;
	bit  in_taken;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [31:0] ror(input logic [31:0] v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	task automatic compress();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = blk[i];
		for (int i = 16; i < 64; i++)
			w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
				+ w[i-7] + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
		e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
		for (int i = 0; i < 64; i++) begin
			t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
				+ K_TABLE[i] + w[i];
			t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
		chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
	endtask

	task automatic place_byte(input logic [5:0] pos, input logic [7:0] v);
		if (pos[1:0] == 2'd0)
			blk[pos[5:2]] = {v, 24'h0};
		else
			blk[pos[5:2]] |= 32'(v) << ((3 - pos[1:0]) * 8);
	endtask

	task automatic restart_hash();
		for (int i = 0; i < 8; i++)
			chain[i] = H_INIT[i];
		fill = '0;
		bit_count = '0;
	endtask

	task automatic hash_transfer(input in_item_t it);
		out_item_t o;
		if (it.has_byte) begin
			place_byte(fill, it.data_byte);
			bit_count += 64'd8;
			fill = fill + 6'd1;
			if (fill == 6'd0)
				compress();
		end
		if (it.end_of_message) begin
			place_byte(fill, PAD_BYTE);
			for (int i = fill[5:2] + 1; i < 16; i++)
				blk[i] = '0;
			if (fill >= PAD_LIMIT) begin
				compress();
				for (int i = 0; i < 14; i++)
					blk[i] = '0;
			end
			blk[14] = bit_count[63:32];
			blk[15] = bit_count[31:0];
			compress();
			for (int i = 0; i < 8; i++) begin
				o.digest_word = chain[i];
				o.digest_last = (i == 7);
				digest_queue.push_back(o);
			end
			restart_hash();
		end
	endtask

	task automatic add_message(input int len, input bit end_on_byte, input bit noise);
		in_item_t it;
		for (int i = 0; i < len; i++) begin
			it.data_byte = 8'($urandom);
			it.has_byte = 1'b1;
			it.end_of_message = end_on_byte && (i == len - 1);
			pending_bytes.push_back(it);
			if (noise && $urandom_range(0, 9) == 0) begin
				it.data_byte = 8'($urandom);
				it.has_byte = 1'b0;
				it.end_of_message = 1'b0;
				pending_bytes.push_back(it);
			end
		end
		if (!end_on_byte || len == 0) begin
			it.data_byte = 8'($urandom);
			it.has_byte = 1'b0;
			it.end_of_message = 1'b1;
			pending_bytes.push_back(it);
		end
	endtask

	initial begin
		in_item_t it;
		restart_hash();
		arst_n = 1'b0;
		stim_done = 1'b0;
		hold_off = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		add_message(0, 1'b0, 1'b0);
		it = '{data_byte: 8'hff, has_byte: 1'b1, end_of_message: 1'b1};
		pending_bytes.push_back(it);
		it = '{data_byte: 8'h00, has_byte: 1'b1, end_of_message: 1'b0};
		pending_bytes.push_back(it);
		it = '{data_byte: 8'hff, has_byte: 1'b0, end_of_message: 1'b0};
		pending_bytes.push_back(it);
		it = '{data_byte: 8'h00, has_byte: 1'b0, end_of_message: 1'b1};
		pending_bytes.push_back(it);
		add_message(56, 1'b1, 1'b0);
		add_message(64, 1'b1, 1'b0);
		for (int m = 0; m < 5; m++)
			add_message($urandom_range(0, 8), $urandom_range(0, 1), 1'b1);
		wait (pending_bytes.size() == 0);
		stim_done = 1'b1;
	end

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.payload <= '0;
			send_gap <= 0;
		end else if (!in_ch.valid || in_taken) begin
			if (in_taken)
				void'(pending_bytes.pop_front());
			if (send_gap > 0) begin
				in_ch.valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_bytes.size() > 0) begin
				in_ch.valid <= 1'b1;
				in_ch.payload <= pending_bytes[0];
				send_gap <= $urandom_range(0, 3) == 0 ?
					($urandom_range(0, 9) == 0 ? $urandom_range(5, 30) : $urandom_range(1, 3)) : 0;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= in_ch.valid && in_ch.ready;
			if (in_ch.valid && in_ch.ready)
				hash_transfer(in_ch.payload);
		end
	end

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			recv_gap <= 0;
		end else if (hold_off < 400 && pending_bytes.size() > 0) begin
			hold_off <= hold_off + 1;
			out_ch.ready <= 1'b0;
		end else if (recv_gap > 0) begin
			out_ch.ready <= 1'b0;
			recv_gap <= recv_gap - 1;
		end else begin
			out_ch.ready <= 1'b1;
			recv_gap <= $urandom_range(0, 3) == 0 ?
				($urandom_range(0, 9) == 0 ? $urandom_range(5, 40) : $urandom_range(1, 3)) : 0;
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (digest_queue.size() == 0) begin
				$error("digest transfer with none expected: %h", out_ch.payload.digest_word);
				failed = 1'b1;
			end else begin
				want = digest_queue.pop_front();
				if (out_ch.payload.digest_word !== want.digest_word) begin
					$error("digest_word: expected %h, got %h", want.digest_word,
						out_ch.payload.digest_word);
					failed = 1'b1;
				end
				if (out_ch.payload.digest_last !== want.digest_last) begin
					$error("digest_last: expected %b, got %b", want.digest_last,
						out_ch.payload.digest_last);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		wait (stim_done);
		wait (digest_queue.size() == 0);
		repeat (300) @(posedge clk);
		if (!failed && digest_queue.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#4000000;
		$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire
